/* hdl/ptw_pkg.sv */
package ptw_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int W = WORD_BITS;
  localparam int RS = 30 - FRAC_BITS;
  localparam longint RS_HALF = (64'sd1 <<< RS) >>> 1;

  // range reduction of w to one turn, one quotient bit per cell
  localparam int ZW = W + RS;
  localparam int MOD_STEPS = W - FRAC_BITS - 2;
  localparam int MSTEP_W = $clog2(MOD_STEPS);
  localparam int ZMW = ZW + MOD_STEPS;
  localparam int AMW = W + MOD_STEPS;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 30;
  localparam int CSTEP_W = $clog2(CORDIC_STEPS);
  localparam int ZCW = 36;
  localparam int XW = 34;

  // products, numerators, quotients
  localparam int SC_W = FRAC_BITS + 3;
  localparam int PW = W + SC_W;
  localparam int NW = PW + 1;
  localparam int QB = W + 1;
  localparam int QSTEP_W = $clog2(QB);
  localparam int DW = W + QB;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam longint TWO_PI_F = (64'sd6746518852 + RS_HALF) >>> RS;

  localparam logic signed [ZCW-1:0] C_TWO_PI = ZCW'(TWO_PI_Q30);
  localparam logic signed [ZCW-1:0] C_PI = ZCW'(64'd3373259426);
  localparam logic signed [ZCW-1:0] C_HALF_PI = ZCW'(64'd1686629713);
  localparam logic signed [XW-1:0] C_GAIN = XW'(64'd652032874);
  localparam logic signed [SC_W-1:0] C_ONE = SC_W'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic signed [W-1:0] w;
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [W-1:0] ang;
  } side_t;

  typedef struct packed {
    logic [ZW-1:0] zmag;
    logic [W-1:0] arem;
    side_t side;
  } mod_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZCW-1:0] z;
    logic flip;
    side_t side;
  } cor_t;

  typedef struct packed {
    logic negx;
    logic negy;
    logic ovfx;
    logic ovfy;
    logic [DW-1:0] remx;
    logic [DW-1:0] remy;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic [W-1:0] d;
    side_t side;
  } div_t;

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    mag_w = v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic signed [SC_W-1:0] q30_round(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    t = (XW+1)'(v) + (XW+1)'(RS_HALF);
    q30_round = SC_W'(t >>> RS);
  endfunction

  function automatic logic signed [ZCW-1:0] atan_q30(input logic [CSTEP_W-1:0] i);
    unique case (i)
      5'd0: atan_q30 = ZCW'(843314856);
      5'd1: atan_q30 = ZCW'(497837829);
      5'd2: atan_q30 = ZCW'(263043836);
      5'd3: atan_q30 = ZCW'(133525158);
      5'd4: atan_q30 = ZCW'(67021686);
      5'd5: atan_q30 = ZCW'(33543515);
      5'd6: atan_q30 = ZCW'(16775850);
      5'd7: atan_q30 = ZCW'(8388437);
      5'd8: atan_q30 = ZCW'(4194282);
      5'd9: atan_q30 = ZCW'(2097149);
      5'd10: atan_q30 = ZCW'(1048575);
      5'd11: atan_q30 = ZCW'(524287);
      5'd12: atan_q30 = ZCW'(262143);
      5'd13: atan_q30 = ZCW'(131071);
      5'd14: atan_q30 = ZCW'(65535);
      5'd15: atan_q30 = ZCW'(32767);
      5'd16: atan_q30 = ZCW'(16383);
      5'd17: atan_q30 = ZCW'(8191);
      5'd18: atan_q30 = ZCW'(4095);
      5'd19: atan_q30 = ZCW'(2047);
      5'd20: atan_q30 = ZCW'(1023);
      5'd21: atan_q30 = ZCW'(511);
      5'd22: atan_q30 = ZCW'(255);
      5'd23: atan_q30 = ZCW'(127);
      5'd24: atan_q30 = ZCW'(63);
      5'd25: atan_q30 = ZCW'(31);
      5'd26: atan_q30 = ZCW'(15);
      5'd27: atan_q30 = ZCW'(8);
      5'd28: atan_q30 = ZCW'(4);
      5'd29: atan_q30 = ZCW'(2);
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

/* hdl/ptw_if.sv */
interface ptw_in_if import ptw_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [W-1:0] ang_rate;
  logic signed [W-1:0] lin_rate_x;
  logic signed [W-1:0] lin_rate_y;

  modport source(output valid, ang_rate, lin_rate_x, lin_rate_y, input ready);
  modport sink(input valid, ang_rate, lin_rate_x, lin_rate_y, output ready);
endinterface

interface ptw_out_if import ptw_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [W-1:0] delta_x;
  logic signed [W-1:0] delta_y;
  logic signed [W-1:0] delta_angle;
  logic saturated;

  modport source(output valid, delta_x, delta_y, delta_angle, saturated, input ready);
  modport sink(input valid, delta_x, delta_y, delta_angle, saturated, output ready);
endinterface

/* hdl/ptw_mod_cell.sv */
module ptw_mod_cell import ptw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic [MSTEP_W-1:0] step,
  input  logic vld_i,
  input  mod_t d_i,
  output logic vld_o,
  output mod_t d_o
);

  logic [ZMW-1:0] zsh;
  logic [AMW-1:0] ash;
  logic zge;
  logic age;

  always_comb begin
    zsh = ZMW'(TWO_PI_Q30) << step;
    ash = AMW'(TWO_PI_F) << step;
    zge = ZMW'(d_i.zmag) >= zsh;
    age = AMW'(d_i.arem) >= ash;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o.side <= d_i.side;
      d_o.zmag <= zge ? ZW'(ZMW'(d_i.zmag) - zsh) : d_i.zmag;
      d_o.arem <= age ? W'(AMW'(d_i.arem) - ash) : d_i.arem;
    end
  end

endmodule

/* hdl/ptw_cordic_cell.sv */
module ptw_cordic_cell import ptw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic [CSTEP_W-1:0] step,
  input  logic vld_i,
  input  cor_t d_i,
  output logic vld_o,
  output cor_t d_o
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZCW-1:0] a;

  always_comb begin
    xs = d_i.x >>> step;
    ys = d_i.y >>> step;
    a = atan_q30(step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o.side <= d_i.side;
      d_o.flip <= d_i.flip;
      if (!d_i.z[ZCW-1]) begin
        d_o.x <= d_i.x - ys;
        d_o.y <= d_i.y + xs;
        d_o.z <= d_i.z - a;
      end else begin
        d_o.x <= d_i.x + ys;
        d_o.y <= d_i.y - xs;
        d_o.z <= d_i.z + a;
      end
    end
  end

endmodule

/* hdl/ptw_div_cell.sv */
module ptw_div_cell import ptw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic [QSTEP_W-1:0] step,
  input  logic vld_i,
  input  div_t d_i,
  output logic vld_o,
  output div_t d_o
);

  logic [DW-1:0] sh;
  logic gex;
  logic gey;
  div_t d_nxt;

  always_comb begin
    sh = DW'(d_i.d) << step;
    gex = d_i.remx >= sh;
    gey = d_i.remy >= sh;
    d_nxt = d_i;
    d_nxt.remx = gex ? d_i.remx - sh : d_i.remx;
    d_nxt.remy = gey ? d_i.remy - sh : d_i.remy;
    d_nxt.qx[step] = gex;
    d_nxt.qy[step] = gey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

/* hdl/planar_twist_integrate_top.sv */
// Planar twist integrator: SE(2) exponential map over unit time.
// in_ch carries one twist request (ang_rate, lin_rate_x, lin_rate_y, Q16.16);
// out_ch returns delta_x, delta_y, delta_angle and the saturated flag.
// Both channels use valid/ready; a request moves when both are high.
// Structure: an input register, then a row of cells that each advance every
// cycle unless the output stalls. 14 range-reduction
// cells (one quotient bit of w mod 2*pi each), a fold stage, 30 CORDIC cells,
// a rounding stage, a multiply stage, a sum stage, a sign/overflow stage,
// 33 restoring-division cells (one quotient bit each, x and y together),
// and the output register.
// Throughput: one request per cycle while the output is not stalled.
// Reset empties every stage; out_ch.valid is low after reset.
// When the receiver stalls with a result waiting, the whole row holds and
// in_ch.ready drops until the result is taken; bubbles never hold it up.
module planar_twist_integrate_top import ptw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ptw_in_if.sink in_ch,
  ptw_out_if.source out_ch
);

  logic en;
  logic out_vld_r;

  logic [MOD_STEPS:0] m_vld;
  mod_t m_d [MOD_STEPS+1];
  logic [CORDIC_STEPS:0] c_vld;
  cor_t c_d [CORDIC_STEPS+1];
  logic [QB:0] q_vld;
  div_t q_d [QB+1];

  logic [W-1:0] in_abs;

  logic signed [ZCW-1:0] zr;
  logic signed [ZCW-1:0] z1;
  logic signed [ZCW-1:0] z2;
  logic flip;
  logic [W-1:0] fw_abs;
  logic signed [W-1:0] ang_nxt;

  logic r_vld_r;
  logic signed [SC_W-1:0] r_s_r;
  logic signed [SC_W-1:0] r_cm_r;
  logic signed [SC_W-1:0] r_om_r;
  side_t r_side_r;
  logic signed [XW-1:0] xf;

  logic p_vld_r;
  logic signed [PW-1:0] p1_r;
  logic signed [PW-1:0] p2_r;
  logic signed [PW-1:0] p3_r;
  logic signed [PW-1:0] p4_r;
  side_t p_side_r;

  logic n_vld_r;
  logic signed [NW-1:0] nx_r;
  logic signed [NW-1:0] ny_r;
  side_t n_side_r;

  logic [W-1:0] nd;
  logic [DW-1:0] magx;
  logic [DW-1:0] magy;

  logic signed [W-1:0] dx_nxt;
  logic signed [W-1:0] dy_nxt;
  logic sat_nxt;
  logic satx;
  logic saty;
  logic signed [W-1:0] dx_r;
  logic signed [W-1:0] dy_r;
  logic signed [W-1:0] ang_r;
  logic sat_r;

  localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // input capture
  assign in_abs = mag_w(in_ch.ang_rate);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld[0] <= 1'b0;
    end else if (en) begin
      m_vld[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_d[0].zmag <= ZW'(in_abs) << RS;
      m_d[0].arem <= in_abs;
      m_d[0].side.w <= in_ch.ang_rate;
      m_d[0].side.vx <= in_ch.lin_rate_x;
      m_d[0].side.vy <= in_ch.lin_rate_y;
      m_d[0].side.ang <= in_ch.ang_rate;
    end
  end

  for (genvar g = 0; g < MOD_STEPS; g++) begin : g_mod
    ptw_mod_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .step(MSTEP_W'(MOD_STEPS - 1 - g)),
      .vld_i(m_vld[g]), .d_i(m_d[g]),
      .vld_o(m_vld[g+1]), .d_o(m_d[g+1])
    );
  end

  // fold to [-pi/2, pi/2]; rotation output
  always_comb begin
    zr = ZCW'(m_d[MOD_STEPS].zmag);
    if (m_d[MOD_STEPS].side.w[W-1]) zr = -zr;
    if (zr > C_PI) z1 = zr - C_TWO_PI;
    else if (zr < -C_PI) z1 = zr + C_TWO_PI;
    else z1 = zr;
    flip = 1'b0;
    z2 = z1;
    if (z1 > C_HALF_PI) begin
      z2 = C_PI - z1;
      flip = 1'b1;
    end else if (z1 < -C_HALF_PI) begin
      z2 = -C_PI - z1;
      flip = 1'b1;
    end
    fw_abs = mag_w(m_d[MOD_STEPS].side.w);
    ang_nxt = m_d[MOD_STEPS].side.w;
    if (fw_abs > W'(TWO_PI_F)) begin
      ang_nxt = m_d[MOD_STEPS].side.w[W-1] ? -$signed(m_d[MOD_STEPS].arem)
                                            : $signed(m_d[MOD_STEPS].arem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld[0] <= 1'b0;
    end else if (en) begin
      c_vld[0] <= m_vld[MOD_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_d[0].x <= C_GAIN;
      c_d[0].y <= '0;
      c_d[0].z <= z2;
      c_d[0].flip <= flip;
      c_d[0].side.w <= m_d[MOD_STEPS].side.w;
      c_d[0].side.vx <= m_d[MOD_STEPS].side.vx;
      c_d[0].side.vy <= m_d[MOD_STEPS].side.vy;
      c_d[0].side.ang <= ang_nxt;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cor
    ptw_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .step(CSTEP_W'(g)),
      .vld_i(c_vld[g]), .d_i(c_d[g]),
      .vld_o(c_vld[g+1]), .d_o(c_d[g+1])
    );
  end

  // round sine and cosine
  assign xf = c_d[CORDIC_STEPS].flip ? -c_d[CORDIC_STEPS].x : c_d[CORDIC_STEPS].x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      n_vld_r <= 1'b0;
      q_vld[0] <= 1'b0;
    end else if (en) begin
      r_vld_r <= c_vld[CORDIC_STEPS];
      p_vld_r <= r_vld_r;
      n_vld_r <= p_vld_r;
      q_vld[0] <= n_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_s_r <= q30_round(c_d[CORDIC_STEPS].y);
      r_cm_r <= q30_round(xf) - C_ONE;
      r_om_r <= C_ONE - q30_round(xf);
      r_side_r <= c_d[CORDIC_STEPS].side;

      p1_r <= r_side_r.vy * r_cm_r;
      p2_r <= r_side_r.vx * r_s_r;
      p3_r <= r_side_r.vx * r_om_r;
      p4_r <= r_side_r.vy * r_s_r;
      p_side_r <= r_side_r;

      nx_r <= NW'(p1_r) + NW'(p2_r);
      ny_r <= NW'(p3_r) + NW'(p4_r);
      n_side_r <= p_side_r;
    end
  end

  // sign, magnitude and quotient overflow
  always_comb begin
    nd = mag_w(n_side_r.w);
    magx = nx_r[NW-1] ? DW'(-nx_r) : DW'(nx_r);
    magy = ny_r[NW-1] ? DW'(-ny_r) : DW'(ny_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_d[0].negx <= nx_r[NW-1] ^ n_side_r.w[W-1];
      q_d[0].negy <= ny_r[NW-1] ^ n_side_r.w[W-1];
      q_d[0].ovfx <= magx >= (DW'(nd) << QB);
      q_d[0].ovfy <= magy >= (DW'(nd) << QB);
      q_d[0].remx <= magx;
      q_d[0].remy <= magy;
      q_d[0].qx <= '0;
      q_d[0].qy <= '0;
      q_d[0].d <= nd;
      q_d[0].side <= n_side_r;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    ptw_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .step(QSTEP_W'(QB - 1 - g)),
      .vld_i(q_vld[g]), .d_i(q_d[g]),
      .vld_o(q_vld[g+1]), .d_o(q_d[g+1])
    );
  end

  // clip and select the zero-rate case
  always_comb begin
    if (!q_d[QB].negx) begin
      satx = q_d[QB].ovfx || (q_d[QB].qx > QB'(POS_LIM));
      dx_nxt = satx ? $signed(POS_LIM) : $signed(W'(q_d[QB].qx));
    end else begin
      satx = q_d[QB].ovfx || (q_d[QB].qx > QB'(NEG_LIM));
      dx_nxt = satx ? $signed(NEG_LIM) : -$signed(W'(q_d[QB].qx));
    end
    if (!q_d[QB].negy) begin
      saty = q_d[QB].ovfy || (q_d[QB].qy > QB'(POS_LIM));
      dy_nxt = saty ? $signed(POS_LIM) : $signed(W'(q_d[QB].qy));
    end else begin
      saty = q_d[QB].ovfy || (q_d[QB].qy > QB'(NEG_LIM));
      dy_nxt = saty ? $signed(NEG_LIM) : -$signed(W'(q_d[QB].qy));
    end
    sat_nxt = satx || saty;
    if (q_d[QB].side.w == '0) begin
      dx_nxt = q_d[QB].side.vx;
      dy_nxt = q_d[QB].side.vy;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= q_vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      ang_r <= (q_d[QB].side.w == '0) ? '0 : q_d[QB].side.ang;
      sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.delta_x = dx_r;
  assign out_ch.delta_y = dy_r;
  assign out_ch.delta_angle = ang_r;
  assign out_ch.saturated = sat_r;

endmodule

/* hdl/ptw_checker.sv */
module ptw_checker import ptw_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [W-1:0] out_dx,
  input logic signed [W-1:0] out_dy,
  input logic out_sat
);

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat |->
      (out_dx == MAXV || out_dx == MINV || out_dy == MAXV || out_dy == MINV))
    else $error("saturated flag without a clipped translation");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

endmodule

bind planar_twist_integrate_top ptw_checker u_ptw_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_dx(out_ch.delta_x),
  .out_dy(out_ch.delta_y),
  .out_sat(out_ch.saturated)
);
